### hdl/qse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_pkg
// Shared constants for the quicksort engine: stream word width and the
// default sizing of the element store.
// ----------------------------------------------------------------------------
package qse_pkg;

  // Width of the value carried on both stream data buses
  localparam int DATA_W = 32;

  // Default sizing handed to the top level
  localparam int DEF_CAPACITY      = 64;
  localparam int DEF_ELEMENT_WIDTH = 32;

endpackage

### hdl/qse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module qse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/quicksort_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine_unit
// Collects signed values into an element store and streams them back out in
// ascending order, sorted by an iterative quicksort with an explicit stack.
// ----------------------------------------------------------------------------
// Usage: words are taken one per cycle on the slave stream while the unit is
// loading. The word with tlast set, or the CAPACITY-th word, closes the set;
// tready then stays low until every sorted word has left on the master
// stream, the greatest flagged with tlast. Sorting runs through one store
// read port and one shared comparator: each scan step reads the store and
// then compares, a swap writes the two elements in turn, and each partition
// adds setup, pivot placement and stack pushes. Already-ordered input is the
// slowest case, since the pivot is taken from the top of each range. Each
// output word is read from the store, registered and held until the sink
// takes it before the next word is read.
// ----------------------------------------------------------------------------
module quicksort_engine_unit
  import qse_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,   // last_in
  // master stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic              m_axis_tlast    // last_out
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = IDX_W + 2;
  localparam int CW    = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;
  localparam int SW    = 2 * IDX_W;

  typedef logic        [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [PW-1:0]            ptr_t;

  // sequencer states
  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_POP    = 5'd2;
  localparam logic [4:0] S_RANGE  = 5'd3;
  localparam logic [4:0] S_PIV    = 5'd4;
  localparam logic [4:0] S_SI     = 5'd5;
  localparam logic [4:0] S_SI_C   = 5'd6;
  localparam logic [4:0] S_SJ     = 5'd7;
  localparam logic [4:0] S_SJ_C   = 5'd8;
  localparam logic [4:0] S_BRK    = 5'd9;
  localparam logic [4:0] S_SW2    = 5'd10;
  localparam logic [4:0] S_FIN    = 5'd11;
  localparam logic [4:0] S_FIN_R  = 5'd12;
  localparam logic [4:0] S_FIN_W  = 5'd13;
  localparam logic [4:0] S_PUSH1  = 5'd14;
  localparam logic [4:0] S_PUSH2  = 5'd15;
  localparam logic [4:0] S_OUT_RD = 5'd16;
  localparam logic [4:0] S_OUT_LD = 5'd17;
  localparam logic [4:0] S_OUT_WT = 5'd18;

  // control registers
  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  ptr_t              i_q, i_d, j_q, j_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  elem_t             pv_q, pv_d, ai_q, ai_d, aj_q, aj_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  // store and stack ports
  logic             es_we;
  logic [IDX_W-1:0] es_waddr, es_raddr;
  elem_t            es_wdata, es_rdata;
  logic             st_we;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  logic [SW-1:0]    st_wdata, st_rdata;

  // helpers
  elem_t             in_elem;
  logic [DATA_W-1:0] out_word;
  elem_t             cmp_a, cmp_b;
  logic              cmp_lt;
  ptr_t              lo_p, hi_p, cnt_p, st_lo_p, st_hi_p;
  logic [CNT_W-1:0]  cnt_m1, sp_m1;
  logic              in_acc, out_acc, push_ok;

  qse_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (es_we),
    .waddr_i (es_waddr),
    .wdata_i (es_wdata),
    .raddr_i (es_raddr),
    .rdata_o (es_rdata)
  );

  qse_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // width adaption between stream words and store elements
  always_comb begin
    in_elem           = '0;
    in_elem[CW-1:0]   = s_axis_tdata[CW-1:0];
    out_word          = '0;
    out_word[CW-1:0]  = es_rdata[CW-1:0];
  end

  // shared signed comparator: scan-i asks elem < pivot, scan-j pivot < elem
  assign cmp_a  = (state_q == S_SJ_C) ? pv_q : es_rdata;
  assign cmp_b  = (state_q == S_SJ_C) ? es_rdata : pv_q;
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  assign lo_p    = ptr_t'(lo_q);
  assign hi_p    = ptr_t'(hi_q);
  assign cnt_p   = ptr_t'(count_q);
  assign st_lo_p = ptr_t'(st_rdata[SW-1:IDX_W]);
  assign st_hi_p = ptr_t'(st_rdata[IDX_W-1:0]);
  assign cnt_m1  = count_q - CNT_W'(1);
  assign sp_m1   = sp_q - CNT_W'(1);
  assign push_ok = sp_q < CNT_W'(CAPACITY);

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sp_d        = sp_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pv_d        = pv_q;
    ai_d        = ai_q;
    aj_d        = aj_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    es_we       = 1'b0;
    es_waddr    = i_q[IDX_W-1:0];
    es_wdata    = aj_q;
    es_raddr    = i_q[IDX_W-1:0];
    st_we       = 1'b0;
    st_waddr    = sp_q[IDX_W-1:0];
    st_wdata    = {lo_q, hi_q};
    st_raddr    = sp_m1[IDX_W-1:0];

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          es_we    = 1'b1;
          es_waddr = count_q[IDX_W-1:0];
          es_wdata = in_elem;
          count_d  = count_q + CNT_W'(1);
          if (s_axis_tlast || count_q == CNT_W'(CAPACITY - 1)) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (count_q >= CNT_W'(2)) begin
          st_we    = 1'b1;
          st_waddr = '0;
          st_wdata = {{IDX_W{1'b0}}, cnt_m1[IDX_W-1:0]};
          sp_d     = CNT_W'(1);
          state_d  = S_POP;
        end else begin
          sp_d    = '0;
          k_d     = '0;
          state_d = S_OUT_RD;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          sp_d    = sp_m1;
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        lo_d     = st_rdata[SW-1:IDX_W];
        hi_d     = st_rdata[IDX_W-1:0];
        es_raddr = st_rdata[IDX_W-1:0];
        i_d      = st_lo_p;
        j_d      = st_hi_p - ptr_t'(1);
        if (st_hi_p >= cnt_p || st_lo_p >= st_hi_p) begin
          state_d = S_POP;
        end else begin
          state_d = S_PIV;
        end
      end
      S_PIV: begin
        pv_d    = es_rdata;
        state_d = S_SI;
      end
      // advance i past elements below the pivot
      S_SI: begin
        es_raddr = i_q[IDX_W-1:0];
        state_d  = (i_q <= j_q) ? S_SI_C : S_SJ;
      end
      S_SI_C: begin
        if (cmp_lt) begin
          i_d     = i_q + ptr_t'(1);
          state_d = S_SI;
        end else begin
          ai_d    = es_rdata;
          state_d = S_SJ;
        end
      end
      // retreat j past elements above the pivot
      S_SJ: begin
        es_raddr = j_q[IDX_W-1:0];
        state_d  = (i_q <= j_q) ? S_SJ_C : S_BRK;
      end
      S_SJ_C: begin
        if (cmp_lt) begin
          j_d     = j_q - ptr_t'(1);
          state_d = S_SJ;
        end else begin
          aj_d    = es_rdata;
          state_d = S_BRK;
        end
      end
      // pointers crossed, or swap the two out-of-place elements
      S_BRK: begin
        if (i_q >= j_q) begin
          state_d = S_FIN;
        end else begin
          es_we    = 1'b1;
          es_waddr = i_q[IDX_W-1:0];
          es_wdata = aj_q;
          state_d  = S_SW2;
        end
      end
      S_SW2: begin
        es_we    = 1'b1;
        es_waddr = j_q[IDX_W-1:0];
        es_wdata = ai_q;
        i_d      = i_q + ptr_t'(1);
        j_d      = j_q - ptr_t'(1);
        state_d  = S_SI;
      end
      // place pivot at i
      S_FIN: begin
        es_raddr = i_q[IDX_W-1:0];
        state_d  = S_FIN_R;
      end
      S_FIN_R: begin
        es_we    = 1'b1;
        es_waddr = hi_q;
        es_wdata = es_rdata;
        state_d  = S_FIN_W;
      end
      S_FIN_W: begin
        es_we    = 1'b1;
        es_waddr = i_q[IDX_W-1:0];
        es_wdata = pv_q;
        state_d  = S_PUSH1;
      end
      // push left part, then right part, if each has two or more elements and the stack has room
      S_PUSH1: begin
        if (i_q >= lo_p + ptr_t'(2) && push_ok) begin
          st_we    = 1'b1;
          st_wdata = {lo_q, IDX_W'(i_q - ptr_t'(1))};
          sp_d     = sp_q + CNT_W'(1);
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (i_q + ptr_t'(2) <= hi_p && push_ok) begin
          st_we    = 1'b1;
          st_wdata = {IDX_W'(i_q + ptr_t'(1)), hi_q};
          sp_d     = sp_q + CNT_W'(1);
        end
        state_d = S_POP;
      end
      // stream the sorted store out
      S_OUT_RD: begin
        es_raddr = k_q[IDX_W-1:0];
        state_d  = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_data_d  = out_word;
        out_last_d  = (k_q == cnt_m1);
        out_valid_d = 1'b1;
        state_d     = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      sp_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pv_q       <= pv_d;
    ai_q       <= ai_d;
    aj_q       <= aj_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_valid_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_OUT_WT)
    else $error("output valid outside output wait");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY) && sp_q <= CNT_W'(CAPACITY))
    else $error("element count or stack pointer out of range");

  a_scan_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SI_C || state_q == S_SJ_C) |-> (i_q <= j_q && j_q < hi_p && i_q >= lo_p))
    else $error("scan pointers outside partition range");

  a_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (s_axis_tready && count_q == '0))
    else $error("store not emptied after last sorted word");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("loading while a sorted word is pending");

endmodule
